/* rtl/core/oct_pkg.sv */
package oct_pkg;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_DATA_W = 16;
   localparam int REG_IDX_W  = 4;
   localparam int OUT_CH_W   = 8;
   localparam int PSC_W      = 3;
   localparam int PSC_CNT_W  = 7;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ACT_OFF    = 2'd0,
      ACT_TOGGLE = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_SET    = 2'd3
   } pin_act_type;

   localparam logic [REG_IDX_W-1:0] REG_CMP_SEL  = 4'd0;
   localparam logic [REG_IDX_W-1:0] REG_IRQ_EN   = 4'd1;
   localparam logic [REG_IDX_W-1:0] REG_ACTIONS  = 4'd2;
   localparam logic [REG_IDX_W-1:0] REG_FLAGS    = 4'd3;
   localparam logic [REG_IDX_W-1:0] REG_COUNT    = 4'd4;
   localparam logic [REG_IDX_W-1:0] REG_CMP_BASE = 4'd5;

   localparam logic [CSR_ADDR_W-1:0] CSR_PRESCALE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENABLE   = 3'd4;

endpackage

/* rtl/core/oct_compare.sv */
module oct_compare #(
   parameter int NUM_CHANNELS = 8,
   parameter int COUNT_WIDTH  = 16
) (
   input  logic [COUNT_WIDTH-1:0]    count_next,
   input  logic [COUNT_WIDTH-1:0]    cmp_values [NUM_CHANNELS],
   input  logic [NUM_CHANNELS-1:0]   cmp_select,
   input  logic [2*NUM_CHANNELS-1:0] pin_actions,
   input  logic [NUM_CHANNELS-1:0]   pins_cur,
   output logic [NUM_CHANNELS-1:0]   match_vec,
   output logic [NUM_CHANNELS-1:0]   pins_next
);
   import oct_pkg::*;

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         match_vec[c] = cmp_select[c] && (cmp_values[c] == count_next);
         pins_next[c] = pins_cur[c];
         if (match_vec[c]) begin
            case (pin_actions[2*c +: 2])
               ACT_TOGGLE: pins_next[c] = ~pins_cur[c];
               ACT_CLEAR:  pins_next[c] = 1'b0;
               ACT_SET:    pins_next[c] = 1'b1;
               default:    pins_next[c] = pins_cur[c];
            endcase
         end
      end
   end

endmodule

/* rtl/core/output_compare_timer_top.sv */
// an accepted item's result is in the output register in the next cycle
// throughput: one item per cycle while the output register is empty or its result is taken
// the pace is set by the single output register, which can load and drain at once
// reset: synchronous, active high, clears counter, prescaler, channel state and
// configuration registers, and empties the output register
module output_compare_timer_top #(
   parameter int NUM_CHANNELS = 8,
   parameter int COUNT_WIDTH  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // reg_index[3:0], write_data[19:4], zero pad
   input  logic [oct_pkg::REQ_DATA_W-1:0]    req_tdata,
   // operation[1:0]
   input  logic [oct_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_data[15:0], flag_bits[23:16], pin_levels[31:24], irq_out[32], zero pad
   output logic [oct_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [oct_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [oct_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [oct_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import oct_pkg::*;

   localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic [PSC_W-1:0]          prescale_ff, prescale_in;
   logic                      enable_ff, enable_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [PSC_CNT_W-1:0]      psc_cnt_ff, psc_cnt_in;
   logic [NUM_CHANNELS-1:0]   cmp_sel_ff, cmp_sel_in;
   logic [NUM_CHANNELS-1:0]   irq_en_ff, irq_en_in;
   logic [2*NUM_CHANNELS-1:0] actions_ff, actions_in;
   logic [NUM_CHANNELS-1:0]   flags_ff, flags_in;
   logic [NUM_CHANNELS-1:0]   pins_ff, pins_in;
   logic [COUNT_WIDTH-1:0]    cmp_ff [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0]    cmp_in [NUM_CHANNELS];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                      accept;
   logic                      csr_wr;
   logic [REG_IDX_W-1:0]      reg_idx;
   logic [REG_DATA_W-1:0]     wdata;
   logic [REG_IDX_W-1:0]      cmp_off;
   logic                      cmp_hit;
   logic [PSC_CNT_W:0]        psc_sum;
   logic [PSC_CNT_W:0]        psc_period;
   logic [COUNT_WIDTH-1:0]    count_inc;
   logic [NUM_CHANNELS-1:0]   match_vec;
   logic [NUM_CHANNELS-1:0]   pins_adv;
   logic [REG_DATA_W-1:0]     rd_data;
   logic                      irq;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign reg_idx    = req_tdata[3:0];
   assign wdata      = req_tdata[19:4];
   assign cmp_off    = reg_idx - REG_CMP_BASE;
   assign cmp_hit    = (reg_idx >= REG_CMP_BASE) &&
                       ({1'b0, cmp_off} < 5'(NUM_CHANNELS));
   assign psc_sum    = {1'b0, psc_cnt_ff} + 1'b1;
   assign psc_period = (PSC_CNT_W+1)'(1) << prescale_ff;
   assign count_inc  = count_ff + 1'b1;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr)
         CSR_PRESCALE: csr_prdata = CSR_DATA_W'(prescale_ff);
         CSR_ENABLE:   csr_prdata = CSR_DATA_W'(enable_ff);
         default:      csr_prdata = '0;
      endcase
   end

   oct_compare #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_compare (
      .count_next  (count_inc),
      .cmp_values  (cmp_ff),
      .cmp_select  (cmp_sel_ff),
      .pin_actions (actions_ff),
      .pins_cur    (pins_ff),
      .match_vec   (match_vec),
      .pins_next   (pins_adv)
   );

   always_comb begin
      prescale_in = prescale_ff;
      enable_in   = enable_ff;
      if (csr_wr) begin
         case (csr_paddr)
            CSR_PRESCALE: prescale_in = csr_pwdata[PSC_W-1:0];
            CSR_ENABLE:   enable_in   = csr_pwdata[0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      count_in   = count_ff;
      psc_cnt_in = psc_cnt_ff;
      cmp_sel_in = cmp_sel_ff;
      irq_en_in  = irq_en_ff;
      actions_in = actions_ff;
      flags_in   = flags_ff;
      pins_in    = pins_ff;
      cmp_in     = cmp_ff;
      rd_data    = '0;
      if (accept) begin
         case (req_tuser)
            OP_TICK: begin
               if (enable_ff) begin
                  if (psc_sum >= psc_period) begin
                     psc_cnt_in = '0;
                     count_in   = count_inc;
                     flags_in   = flags_ff | match_vec;
                     pins_in    = pins_adv;
                  end else begin
                     psc_cnt_in = psc_sum[PSC_CNT_W-1:0];
                  end
               end
            end
            OP_READ: begin
               case (reg_idx)
                  REG_CMP_SEL: rd_data = REG_DATA_W'(cmp_sel_ff);
                  REG_IRQ_EN:  rd_data = REG_DATA_W'(irq_en_ff);
                  REG_ACTIONS: rd_data = REG_DATA_W'(actions_ff);
                  REG_FLAGS:   rd_data = REG_DATA_W'(flags_ff);
                  REG_COUNT:   rd_data = REG_DATA_W'(count_ff);
                  default: begin
                     if (cmp_hit) begin
                        rd_data = REG_DATA_W'(cmp_ff[cmp_off[CH_IDX_W-1:0]]);
                     end
                  end
               endcase
            end
            OP_WRITE: begin
               case (reg_idx)
                  REG_CMP_SEL: cmp_sel_in = wdata[NUM_CHANNELS-1:0];
                  REG_IRQ_EN:  irq_en_in  = wdata[NUM_CHANNELS-1:0];
                  REG_ACTIONS: actions_in = wdata[2*NUM_CHANNELS-1:0];
                  REG_FLAGS:   flags_in   = flags_ff & ~wdata[NUM_CHANNELS-1:0];
                  REG_COUNT:   ;
                  default: begin
                     if (cmp_hit) begin
                        cmp_in[cmp_off[CH_IDX_W-1:0]] = COUNT_WIDTH'(wdata);
                     end
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   assign irq = |(flags_in & irq_en_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, irq, OUT_CH_W'(pins_in), OUT_CH_W'(flags_in), rd_data};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff  <= '0;
         enable_ff    <= 1'b0;
         count_ff     <= '0;
         psc_cnt_ff   <= '0;
         cmp_sel_ff   <= '0;
         irq_en_ff    <= '0;
         actions_ff   <= '0;
         flags_ff     <= '0;
         pins_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            cmp_ff[c] <= '0;
         end
      end else begin
         prescale_ff  <= prescale_in;
         enable_ff    <= enable_in;
         count_ff     <= count_in;
         psc_cnt_ff   <= psc_cnt_in;
         cmp_sel_ff   <= cmp_sel_in;
         irq_en_ff    <= irq_en_in;
         actions_ff   <= actions_in;
         flags_ff     <= flags_in;
         pins_ff      <= pins_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_ff       <= cmp_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/core/oct_checker.sv */
module oct_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [oct_pkg::REQ_DATA_W-1:0]    req_tdata,
   input logic [oct_pkg::REQ_USER_W-1:0]    req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [oct_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import oct_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // every accepted item shows up as a result in the next cycle
   a_rsp_next: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item gave no result");

   // only reads return data
   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != OP_READ |=> rsp_tdata[15:0] == 16'd0)
      else $error("read data on non-read item");

   // interrupt only with a flag set
   a_irq_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[23:16] != 8'd0)
      else $error("interrupt without flag");

   // an empty output stage never blocks input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

endmodule

bind output_compare_timer_top oct_checker u_oct_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import oct_pkg::*;

   localparam logic [1:0]           OP_RESERVED    = 2'd3;
   localparam logic [REG_IDX_W-1:0] REG_SPARE      = 4'd13;
   localparam logic [REG_IDX_W-1:0] REG_LAST       = 4'd15;
   localparam int                   WATCHDOG_LIMIT = 5000;
   localparam int                   HOLD_CYCLES    = 300;

   typedef struct packed {
      logic        irq;
      logic [7:0]  pins;
      logic [7:0]  flags;
      logic [15:0] rdata;
   } timer_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predicted timer state
   logic [2:0]  psc_sel   = '0;
   logic        timer_en  = '0;
   logic [15:0] count_q   = '0;
   logic [6:0]  psc_count = '0;
   logic [7:0]  cmp_sel_q = '0;
   logic [7:0]  irq_en_q  = '0;
   logic [15:0] act_q     = '0;
   logic [7:0]  flags_q   = '0;
   logic [7:0]  pins_q    = '0;
   logic [15:0] cmp_q [8] = '{default: '0};

   timer_result_type pending_results [$];
   timer_result_type got_result;
   timer_result_type want_result;

   int  mismatches      = 0;
   int  items_sent      = 0;
   int  results_checked = 0;
   int  tx_idle_pct     = 0;
   int  rx_stall_pct    = 0;
   int  quiet_cycles    = 0;
   logic rx_hold;

   output_compare_timer_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic void apply_timer_op(logic [1:0] op, logic [3:0] idx, logic [15:0] data);
      timer_result_type res;
      int nxt;
      res = '0;
      case (op)
         OP_TICK: begin
            if (timer_en) begin
               nxt = int'(psc_count) + 1;
               if (nxt >= (1 << psc_sel)) begin
                  psc_count = '0;
                  count_q = count_q + 16'd1;
                  for (int c = 0; c < 8; c++) begin
                     if (cmp_sel_q[c] && cmp_q[c] == count_q) begin
                        flags_q[c] = 1'b1;
                        case (pin_act_type'(act_q[2*c +: 2]))
                           ACT_TOGGLE: pins_q[c] = ~pins_q[c];
                           ACT_CLEAR:  pins_q[c] = 1'b0;
                           ACT_SET:    pins_q[c] = 1'b1;
                           default:    ;
                        endcase
                     end
                  end
               end else begin
                  psc_count = nxt[6:0];
               end
            end
         end
         OP_READ: begin
            case (idx)
               REG_CMP_SEL: res.rdata = {8'h00, cmp_sel_q};
               REG_IRQ_EN:  res.rdata = {8'h00, irq_en_q};
               REG_ACTIONS: res.rdata = act_q;
               REG_FLAGS:   res.rdata = {8'h00, flags_q};
               REG_COUNT:   res.rdata = count_q;
               default: begin
                  if (idx >= REG_CMP_BASE && idx < REG_SPARE)
                     res.rdata = cmp_q[3'(idx - REG_CMP_BASE)];
               end
            endcase
         end
         OP_WRITE: begin
            case (idx)
               REG_CMP_SEL: cmp_sel_q = data[7:0];
               REG_IRQ_EN:  irq_en_q = data[7:0];
               REG_ACTIONS: act_q = data;
               REG_FLAGS:   flags_q = flags_q & ~data[7:0];
               REG_COUNT:   ;
               default: begin
                  if (idx >= REG_CMP_BASE && idx < REG_SPARE)
                     cmp_q[3'(idx - REG_CMP_BASE)] = data;
               end
            endcase
         end
         default: ;
      endcase
      res.flags = flags_q;
      res.pins  = pins_q;
      res.irq   = |(flags_q & irq_en_q);
      pending_results.push_back(res);
   endfunction

   task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got_result = rsp_tdata[32:0];
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t unexpected item: expected none actual %h", $time, rsp_tdata);
         end else begin
            want_result = pending_results.pop_front();
            results_checked++;
            check_field("read_data", want_result.rdata, got_result.rdata);
            check_field("flag_bits", 16'(want_result.flags), 16'(got_result.flags));
            check_field("pin_levels", 16'(want_result.pins), 16'(got_result.pins));
            check_field("irq_out", 16'(want_result.irq), 16'(got_result.irq));
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable)
          || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL output_compare_timer_top");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [3:0] idx, input logic [15:0] data);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0000, data, idx};
      do begin
         @(posedge clock);
      end while (!(req_tvalid && req_tready));
      apply_timer_op(op, idx, data);
      items_sent++;
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == CSR_PRESCALE)
         psc_sel = data[2:0];
      else if (addr == CSR_ENABLE)
         timer_en = data[0];
      @(posedge clock);
   endtask

   // arm one channel one to four counts ahead, then send one to twelve ticks
   task automatic arm_and_tick();
      int c;
      logic [3:0] idx;
      c = $urandom_range(0, 7);
      idx = REG_CMP_BASE + 4'(c);
      send_item(OP_WRITE, idx, count_q + 16'($urandom_range(1, 4)));
      if ($urandom_range(0, 1))
         send_item(OP_WRITE, REG_CMP_SEL, 16'($urandom) | (16'd1 << c));
      if ($urandom_range(0, 1))
         send_item(OP_WRITE, REG_ACTIONS, 16'($urandom));
      if ($urandom_range(0, 3) == 0)
         send_item(OP_WRITE, REG_IRQ_EN, 16'($urandom));
      repeat ($urandom_range(1, 12))
         send_item(OP_TICK, 4'($urandom), 16'($urandom));
      if ($urandom_range(0, 1))
         send_item(OP_READ, 4'($urandom_range(0, 15)), 16'($urandom));
      if ($urandom_range(0, 2) == 0)
         send_item(OP_WRITE, REG_FLAGS, 16'($urandom));
   endtask

   task automatic test_directed();
      send_item(OP_TICK, REG_CMP_SEL, 16'h0000);
      send_item(OP_READ, REG_COUNT, 16'h0000);
      send_item(OP_WRITE, REG_CMP_SEL, 16'hffff);
      send_item(OP_WRITE, REG_IRQ_EN, 16'h00f0);
      // ch0 toggle, ch1 clear, ch2 set, ch3 off, repeated
      send_item(OP_WRITE, REG_ACTIONS, 16'h3939);
      for (int c = 0; c < 7; c++)
         send_item(OP_WRITE, REG_CMP_BASE + 4'(c), 16'h0001);
      send_item(OP_WRITE, REG_CMP_BASE + 4'd7, 16'hffff);
      send_item(OP_WRITE, REG_COUNT, 16'hffff);
      send_item(OP_WRITE, REG_SPARE, 16'hffff);
      send_item(OP_READ, REG_LAST, 16'h0000);
      send_item(OP_RESERVED, REG_LAST, 16'hffff);
      wait_drain();
      csr_write(CSR_PRESCALE, 32'd0);
      csr_write(CSR_ENABLE, 32'd1);
      send_item(OP_TICK, REG_CMP_SEL, 16'h0000);
      send_item(OP_READ, REG_FLAGS, 16'h0000);
      send_item(OP_WRITE, REG_FLAGS, 16'h000f);
      send_item(OP_READ, REG_FLAGS, 16'h0000);
      send_item(OP_READ, REG_CMP_BASE + 4'd7, 16'h0000);
      send_item(OP_READ, REG_COUNT, 16'h0000);
      wait_drain();
   endtask

   // lowering the prescaler after the tick count has passed the new period, then ticking while disabled
   task automatic test_prescale_change();
      csr_write(CSR_PRESCALE, 32'd7);
      repeat (100) send_item(OP_TICK, REG_CMP_SEL, 16'h0000);
      send_item(OP_READ, REG_COUNT, 16'h0000);
      wait_drain();
      csr_write(CSR_PRESCALE, 32'd2);
      repeat (9) send_item(OP_TICK, REG_CMP_SEL, 16'h0000);
      send_item(OP_READ, REG_COUNT, 16'h0000);
      wait_drain();
      csr_write(CSR_ENABLE, 32'd0);
      repeat (4) send_item(OP_TICK, REG_CMP_SEL, 16'h0000);
      send_item(OP_READ, REG_COUNT, 16'h0000);
      wait_drain();
   endtask

   task automatic test_backpressure();
      wait_drain();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      csr_write(CSR_PRESCALE, 32'd0);
      csr_write(CSR_ENABLE, 32'd1);
      fork
         begin
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rx_hold <= 1'b0;
         end
      join_none
      repeat (5) arm_and_tick();
      wait_drain();
   endtask

   task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int psc,
                                      input int en, input int n);
      int stop_at;
      wait_drain();
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      csr_write(CSR_PRESCALE, 32'(psc));
      csr_write(CSR_ENABLE, 32'(en));
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 99) < 65)
            arm_and_tick();
         else
            send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 16'($urandom));
      end
      wait_drain();
   endtask

   initial begin
      clock       = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      rx_hold    <= 1'b0;
      csr_psel   <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr  <= '0;
      csr_pwdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_prescale_change();
      test_backpressure();
      test_random_traffic(0, 0, 0, 1, 300);
      test_random_traffic(45, 0, 3, 1, 400);
      test_random_traffic(0, 45, 0, 1, 400);
      test_random_traffic(34, 34, 1, 1, 400);
      test_random_traffic(0, 0, 7, 1, 60);
      test_random_traffic(34, 34, 5, 0, 60);
      wait_drain();

      $display("ran %0d items, checked %0d results", items_sent, results_checked);
      $display("prescale 0 to 7, timer on and off, four flow-control mixes, long output hold-off");
      if (mismatches == 0)
         $display("PASS output_compare_timer_top");
      else
         $display("FAIL output_compare_timer_top");
      $finish;
   end

endmodule

/* output_compare_timer_top.f */
rtl/core/oct_pkg.sv
rtl/core/oct_compare.sv
rtl/core/output_compare_timer_top.sv
rtl/core/oct_checker.sv
tb/sv/tb.sv
